/* design/afs_pkg.sv */
// ============================================================================
// afs_pkg - frame skip pacer shared definitions
// Types, register indexes and constants used by the pacer and its channels.
// ============================================================================
package afs_pkg;

   typedef logic [31:0] usec_type;
   typedef logic [19:0] period_type;
   typedef logic [15:0] count_type;
   typedef logic [3:0]  skip_cnt_type;
   typedef logic        csr_idx_type;

   // configuration register indexes
   localparam csr_idx_type REG_FRAME_PERIOD = 1'b0;
   localparam csr_idx_type REG_AUTO_SKIP    = 1'b1;

   localparam period_type   PERIOD_RESET = 20'd16666;
   localparam usec_type     USEC_PER_SEC = 32'd1000000;
   localparam skip_cnt_type MAX_SKIP     = 4'd10;
   localparam count_type    COUNT_MAX    = 16'hFFFF;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_STEP   = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

endpackage

/* design/afs_if.sv */
// ============================================================================
// afs_if - frame skip pacer channels
// Request, response and register write channels with valid/ready handshake.
// ============================================================================
interface afs_req_if;
   import afs_pkg::*;
   logic     valid;
   logic     ready;
   logic     mode;
   usec_type now;

   modport source (output valid, output mode, output now, input ready);
   modport sink   (input valid, input mode, input now, output ready);
endinterface

interface afs_rsp_if;
   import afs_pkg::*;
   logic      valid;
   logic      ready;
   logic      skip;
   logic      wait_res;
   usec_type  wait_until;
   logic      fps_valid;
   count_type fps_count;

   modport source (output valid, output skip, output wait_res, output wait_until,
                   output fps_valid, output fps_count, input ready);
   modport sink   (input valid, input skip, input wait_res, input wait_until,
                   input fps_valid, input fps_count, output ready);
endinterface

interface afs_csr_if;
   import afs_pkg::*;
   logic        valid;
   logic        ready;
   csr_idx_type index;
   period_type  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/auto_frame_skip_pacer_top.sv */
// ============================================================================
// auto_frame_skip_pacer_top - automatic frame skip pacer
// Decides per emulated video frame whether to render, wait or skip.
// ============================================================================
// One request is handled at a time. A restart, a first frame, a skipped
// frame, an early frame or any frame with auto skip on off passes through
// the sequencer steps accept, update and finish. Its response is loaded
// into the response register at the end of the finish step. A late frame
// with auto skip on also runs the skip count through a single shared
// compare-subtract unit, one frame period per cycle, before it finishes.
// The finish step also holds while an older response still sits
// unconsumed in the response register. req_bus.ready is high only while
// the sequencer is idle; a finished response waits in its own register, so
// the next request can be taken before the previous response is consumed.
// Register writes are always accepted and take effect on the next cycle.
module auto_frame_skip_pacer_top (
   input  logic            clock,
   input  logic            reset,
   afs_req_if.sink         req_bus,
   afs_rsp_if.source       rsp_bus,
   afs_csr_if.sink         csr_bus
);
   import afs_pkg::*;

   // configuration
   period_type   period_ff, period_in;
   logic         auto_ff, auto_in;

   // pacing state
   state_type    state_ff, state_in;
   logic         first_ff, first_in;
   usec_type     target_ff, target_in;
   skip_cnt_type skips_ff, skips_in;
   usec_type     window_ff, window_in;
   count_type    count_ff, count_in;

   // captured request
   logic         mode_ff, mode_in;
   usec_type     now_ff, now_in;

   // divider working registers
   usec_type     rem_ff, rem_in;
   skip_cnt_type quo_ff, quo_in;

   // staged result
   logic         res_skip_ff, res_skip_in;
   logic         res_wait_ff, res_wait_in;
   usec_type     res_until_ff, res_until_in;
   logic         res_fv_ff, res_fv_in;
   count_type    res_fc_ff, res_fc_in;

   // response register
   logic         out_valid_ff, out_valid_in;
   logic         out_skip_ff, out_skip_in;
   logic         out_wait_ff, out_wait_in;
   usec_type     out_until_ff, out_until_in;
   logic         out_fv_ff, out_fv_in;
   count_type    out_fc_ff, out_fc_in;

   logic         req_take;
   logic         out_free;
   usec_type     tgt_next;
   usec_type     win_diff;
   count_type    count_inc;
   logic         rem_below;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign out_free      = !out_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.skip       = out_skip_ff;
   assign rsp_bus.wait_res   = out_wait_ff;
   assign rsp_bus.wait_until = out_until_ff;
   assign rsp_bus.fps_valid  = out_fv_ff;
   assign rsp_bus.fps_count  = out_fc_ff;

   // per-frame arithmetic
   assign tgt_next  = target_ff + {12'd0, period_ff};
   assign win_diff  = now_ff - window_ff;
   assign count_inc = (count_ff != COUNT_MAX) ? count_ff + 16'd1 : count_ff;
   // shared compare-subtract unit of the skip divider
   assign rem_below = (rem_ff < {12'd0, period_ff});

   // register writes
   always_comb begin
      period_in = period_ff;
      auto_in   = auto_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_FRAME_PERIOD: period_in = csr_bus.data;
            REG_AUTO_SKIP:    auto_in   = csr_bus.data[0];
            default:          period_in = period_ff;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      first_in     = first_ff;
      target_in    = target_ff;
      skips_in     = skips_ff;
      window_in    = window_ff;
      count_in     = count_ff;
      mode_in      = mode_ff;
      now_in       = now_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      res_skip_in  = res_skip_ff;
      res_wait_in  = res_wait_ff;
      res_until_in = res_until_ff;
      res_fv_in    = res_fv_ff;
      res_fc_in    = res_fc_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               mode_in  = req_bus.mode;
               now_in   = req_bus.now;
               state_in = ST_STEP;
            end
         end

         ST_STEP: begin
            res_skip_in  = 1'b0;
            res_wait_in  = 1'b0;
            res_fv_in    = 1'b0;
            res_fc_in    = '0;
            state_in     = ST_FINISH;
            if (mode_ff) begin
               // restart: arm for the next frame, all-zero response
               first_in     = 1'b1;
               res_until_in = '0;
            end else if (first_ff) begin
               // first frame after restart latches the target
               first_in     = 1'b0;
               target_in    = now_ff;
               count_in     = '0;
               window_in    = '0;
               res_until_in = now_ff;
            end else begin
               target_in    = tgt_next;
               res_until_in = tgt_next;
               if (skips_ff != '0) begin
                  skips_in    = skips_ff - 4'd1;
                  res_skip_in = 1'b1;
               end else begin
                  res_wait_in = auto_ff && (now_ff < tgt_next);
                  // frame rate window
                  count_in = count_inc;
                  if (win_diff >= USEC_PER_SEC) begin
                     res_fv_in = 1'b1;
                     res_fc_in = count_inc - 16'd1;
                     count_in  = '0;
                     window_in = now_ff;
                  end
                  // late frame: count whole periods behind
                  if (auto_ff && (now_ff >= tgt_next)) begin
                     rem_in   = now_ff - tgt_next;
                     quo_in   = '0;
                     state_in = ST_DIVIDE;
                  end
               end
            end
         end

         ST_DIVIDE: begin
            if ((quo_ff == MAX_SKIP) || rem_below) begin
               skips_in = quo_ff;
               state_in = ST_FINISH;
            end else begin
               rem_in = rem_ff - {12'd0, period_ff};
               quo_in = quo_ff + 4'd1;
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // response register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_skip_in  = out_skip_ff;
      out_wait_in  = out_wait_ff;
      out_until_in = out_until_ff;
      out_fv_in    = out_fv_ff;
      out_fc_in    = out_fc_ff;
      if (out_valid_ff && rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
      if ((state_ff == ST_FINISH) && out_free) begin
         out_valid_in = 1'b1;
         out_skip_in  = res_skip_ff;
         out_wait_in  = res_wait_ff;
         out_until_in = res_until_ff;
         out_fv_in    = res_fv_ff;
         out_fc_in    = res_fc_ff;
      end
   end

   // control and pacing state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         period_ff    <= PERIOD_RESET;
         auto_ff      <= 1'b0;
         first_ff     <= 1'b1;
         target_ff    <= '0;
         skips_ff     <= '0;
         window_ff    <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         auto_ff      <= auto_in;
         first_ff     <= first_in;
         target_ff    <= target_in;
         skips_ff     <= skips_in;
         window_ff    <= window_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      now_ff       <= now_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      res_skip_ff  <= res_skip_in;
      res_wait_ff  <= res_wait_in;
      res_until_ff <= res_until_in;
      res_fv_ff    <= res_fv_in;
      res_fc_ff    <= res_fc_in;
      out_skip_ff  <= out_skip_in;
      out_wait_ff  <= out_wait_in;
      out_until_ff <= out_until_in;
      out_fv_ff    <= out_fv_in;
      out_fc_ff    <= out_fc_in;
   end

   // checks
   a_skips_bounded: assert property (@(posedge clock) disable iff (reset)
      skips_ff <= MAX_SKIP)
      else $error("pending skip count above limit");

   a_quo_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (quo_ff <= MAX_SKIP))
      else $error("skip quotient above limit");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_bus.ready)
      else $error("request taken while another is in flight");

   a_skip_no_wait: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_skip_ff && (out_wait_ff || out_fv_ff)))
      else $error("skipped frame reports wait or rate window");

endmodule
